// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("duration parser check failed");

// Property checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("duration parser reset check failed");

`endif

// ===== hdl/dur_pkg.sv =====
// Types and constants of the duration string parser.
package dur_pkg;

  localparam int unsigned BUFFER_SIZE_DEF = 512;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_SIGN  = 3'd1,
    PH_GAP   = 3'd2,
    PH_NUM   = 3'd3,
    PH_NUMSP = 3'd4,
    PH_MPEND = 3'd5,
    PH_ERR   = 3'd6,
    PH_END   = 3'd7
  } phase_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_TOO_LONG  = 3'd2;
  localparam logic [2:0] ST_SIGN_ONLY = 3'd3;
  localparam logic [2:0] ST_EXP_NUM   = 3'd4;
  localparam logic [2:0] ST_RANGE     = 3'd5;

  // Parser state carried from one character to the next.
  typedef struct packed {
    phase_t      ph;
    logic        neg;
    logic [63:0] tot;
    logic [30:0] num;
    logic        big;
    logic [2:0]  ferr;
  } dur_state_t;

  localparam dur_state_t STATE_RST = '{
    ph:   PH_LEAD,
    neg:  1'b0,
    tot:  64'd0,
    num:  31'd0,
    big:  1'b0,
    ferr: ST_OK
  };

endpackage

// ===== hdl/dur_step.sv =====
// Next-state and result logic for one character of the duration parser.
module dur_step
  import dur_pkg::*;
#(
  parameter int unsigned BUFFER_SIZE = BUFFER_SIZE_DEF,
  localparam int unsigned CNT_W = $clog2(BUFFER_SIZE + 1)
) (
  input  dur_state_t         st,
  input  logic [CNT_W-1:0]   cnt,
  input  logic [CNT_W-1:0]   tlen,
  input  logic [7:0]         char_code,
  input  logic               is_last,
  output dur_state_t         st_nxt,
  output logic [CNT_W-1:0]   cnt_nxt,
  output logic [CNT_W-1:0]   tlen_nxt,
  output logic [63:0]        res_total,
  output logic [2:0]         res_status
);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_D  = 8'h44;
  localparam logic [7:0] CH_UP_H  = 8'h48;
  localparam logic [7:0] CH_UP_M  = 8'h4d;
  localparam logic [7:0] CH_UP_S  = 8'h53;
  localparam logic [7:0] CH_UP_W  = 8'h57;
  localparam logic [7:0] CH_LO_D  = 8'h64;
  localparam logic [7:0] CH_LO_H  = 8'h68;
  localparam logic [7:0] CH_LO_M  = 8'h6d;
  localparam logic [7:0] CH_LO_S  = 8'h73;
  localparam logic [7:0] CH_LO_W  = 8'h77;

  localparam logic [19:0] SEC_WEEK = 20'd604800;
  localparam logic [19:0] SEC_DAY  = 20'd86400;
  localparam logic [19:0] SEC_HOUR = 20'd3600;
  localparam logic [19:0] SEC_MIN  = 20'd60;
  localparam logic [19:0] SEC_ONE  = 20'd1;
  localparam logic [34:0] MAX_NUMBER = 35'd1000000000;
  // floor(n / 1000) = (n * ceil(2^40 / 1000)) >> 40, exact for n below 2^31.
  localparam logic [30:0] MS_RECIP = 31'd1099511628;
  localparam int unsigned MS_SHIFT = 40;

  function automatic logic [2:0] first_err(input logic [2:0] cur, input logic [2:0] code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  logic        ws;
  logic        dig;
  logic        active;
  logic        fin;
  logic [3:0]  dval;
  logic [34:0] num10;
  dur_state_t  p;
  dur_state_t  f;
  logic [19:0] mulk;
  logic        use_ms;
  logic        do_gap;
  logic        do_unit;
  logic [50:0] prod_k;
  logic [61:0] prod_ms;
  logic [50:0] add_a;
  logic [36:0] add_b;
  logic [51:0] term;
  logic [CNT_W-1:0] cnt_inc;

  assign ws     = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
  assign dig    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign dval   = char_code[3:0];
  assign num10  = 35'(st.num) * 35'd10 + 35'(dval);
  assign active = (st.ph != PH_END) && (char_code != CH_NUL);
  assign fin    = (st.ph != PH_END) && ((char_code == CH_NUL) || is_last);

  // Character handling: phase transitions and the scaled term to add.
  always_comb begin
    p       = st;
    mulk    = '0;
    use_ms  = 1'b0;
    do_gap  = 1'b0;
    do_unit = 1'b0;
    if (active) begin
      unique case (st.ph)
        PH_LEAD: begin
          if (!ws) begin
            if (char_code == CH_MINUS) begin
              p.neg = 1'b1;
              p.ph  = PH_SIGN;
            end else if (char_code == CH_PLUS) begin
              p.ph = PH_SIGN;
            end else begin
              do_gap = 1'b1;
            end
          end
        end
        PH_SIGN: begin
          if (!ws) begin
            do_gap = 1'b1;
          end
        end
        PH_GAP: begin
          do_gap = 1'b1;
        end
        PH_NUM: begin
          if (dig) begin
            if (num10 > MAX_NUMBER) begin
              p.num = 31'(MAX_NUMBER + 35'd1);
              p.big = 1'b1;
            end else begin
              p.num = 31'(num10);
            end
          end else if (st.big) begin
            p.ferr = first_err(st.ferr, ST_RANGE);
            p.ph   = PH_ERR;
          end else if (ws) begin
            p.ph = PH_NUMSP;
          end else begin
            do_unit = 1'b1;
          end
        end
        PH_NUMSP: begin
          if (!ws) begin
            do_unit = 1'b1;
          end
        end
        PH_MPEND: begin
          if (char_code == CH_LO_S) begin
            use_ms = 1'b1;
            p.ph   = PH_GAP;
          end else begin
            mulk   = SEC_MIN;
            do_gap = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (do_unit) begin
        p.ph = PH_GAP;
        case (char_code) inside
          CH_LO_W, CH_UP_W: mulk = SEC_WEEK;
          CH_LO_D, CH_UP_D: mulk = SEC_DAY;
          CH_LO_H, CH_UP_H: mulk = SEC_HOUR;
          CH_UP_M:          mulk = SEC_MIN;
          CH_LO_S, CH_UP_S: mulk = SEC_ONE;
          CH_LO_M:          p.ph = PH_MPEND;
          default: begin
            // Any other byte closes a bare number and is then parsed anew.
            mulk   = SEC_ONE;
            do_gap = 1'b1;
          end
        endcase
      end

      if (do_gap) begin
        p.ph = PH_GAP;
        if (dig) begin
          p.num = 31'(dval);
          p.big = 1'b0;
          p.ph  = PH_NUM;
        end else if (!ws) begin
          p.ferr = first_err(p.ferr, ST_EXP_NUM);
          p.ph   = PH_ERR;
        end
      end
    end
  end

  assign prod_k  = 51'(st.num) * 51'(mulk);
  assign prod_ms = 62'(st.num) * 62'(MS_RECIP);
  assign add_a   = use_ms ? 51'(prod_ms[61:MS_SHIFT]) : prod_k;

  // End of string: close whatever token is still open.
  always_comb begin
    f     = p;
    add_b = '0;
    if (fin) begin
      case (p.ph)
        PH_LEAD:  f.ferr = first_err(p.ferr, ST_EMPTY);
        PH_SIGN:  f.ferr = first_err(p.ferr, ST_SIGN_ONLY);
        PH_NUM: begin
          if (p.big) begin
            f.ferr = first_err(p.ferr, ST_RANGE);
          end else begin
            add_b = 37'(p.num);
          end
        end
        PH_NUMSP: add_b = 37'(p.num);
        PH_MPEND: add_b = (37'(p.num) << 6) - (37'(p.num) << 2);
        default: begin
        end
      endcase
      f.ph = PH_END;
    end
  end

  // A negative string accumulates downward, so the total needs no final negate.
  assign term = 52'(add_a) + 52'(add_b);

  always_comb begin
    st_nxt     = f;
    st_nxt.tot = f.neg ? (st.tot - 64'(term)) : (st.tot + 64'(term));
  end

  assign cnt_inc = (cnt < CNT_W'(BUFFER_SIZE)) ? (cnt + CNT_W'(1)) : cnt;

  always_comb begin
    cnt_nxt  = cnt;
    tlen_nxt = tlen;
    if (active && ((st.ph != PH_LEAD) || !ws)) begin
      cnt_nxt = cnt_inc;
      if (!ws) begin
        tlen_nxt = cnt_inc;
      end
    end
  end

  always_comb begin
    res_status = f.ferr;
    if ((f.ferr != ST_EMPTY) && (tlen_nxt >= CNT_W'(BUFFER_SIZE))) begin
      res_status = ST_TOO_LONG;
    end
    res_total = (res_status == ST_OK) ? st_nxt.tot : 64'd0;
  end

endmodule

// ===== hdl/duration_string_parser.sv =====
// Top level of the duration string parser: handshakes, state and result register.
//
// The block reads a duration string such as "1d 2h30m" or "-90s", one byte per
// input word, and returns one result word (total seconds and a status) for the
// byte flagged with in_is_last. Both channels use valid/ready; a word moves on a
// rising edge where valid and ready are both high.
//
// The result for a string enters the result register as its last byte leaves
// the input register. Throughput: one byte per cycle across string boundaries
// while results are taken. Each byte passes through an input register, one
// pass of combinational step logic (a small constant multiply and a 64-bit
// add) and then updates the parser state or loads the result register.
//
// When the receiver stalls, the result register holds its word; bytes of the
// next string keep flowing until its own last byte reaches the step logic,
// and only then does in_ready drop. Synchronous active-low reset clears the
// input and result valid flags and returns the parser to its idle state, so
// the block is ready for a new string as soon as reset is released.
module duration_string_parser
  import dur_pkg::*;
#(
  parameter int unsigned BUFFER_SIZE = BUFFER_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_total_seconds,
  output logic [2:0]  out_status
);

  localparam int unsigned CNT_W = $clog2(BUFFER_SIZE + 1);

  // Input register stage.
  logic       in_v_r;
  logic [7:0] in_char_r;
  logic       in_last_r;

  // Parser state between bytes of a string.
  dur_state_t       st_r;
  dur_state_t       st_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] tlen_r;
  logic [CNT_W-1:0] tlen_nxt;

  // Result register.
  logic        out_v_r;
  logic [63:0] out_total_r;
  logic [2:0]  out_status_r;

  logic [63:0] res_total;
  logic [2:0]  res_status;
  logic        out_free;
  logic        consume;

  // A byte leaves the input register unless it is a last byte whose result
  // has nowhere to go yet.
  assign out_free = !out_v_r || out_ready;
  assign consume  = in_v_r && (!in_last_r || out_free);
  assign in_ready = !in_v_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_char_code;
      in_last_r <= in_is_last;
    end
  end

  dur_step #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_step (
    .st         (st_r),
    .cnt        (cnt_r),
    .tlen       (tlen_r),
    .char_code  (in_char_r),
    .is_last    (in_last_r),
    .st_nxt     (st_nxt),
    .cnt_nxt    (cnt_nxt),
    .tlen_nxt   (tlen_nxt),
    .res_total  (res_total),
    .res_status (res_status)
  );

  // The state returns to idle after every last byte, ready for the next string.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= STATE_RST;
      cnt_r  <= '0;
      tlen_r <= '0;
    end else if (consume) begin
      if (in_last_r) begin
        st_r   <= STATE_RST;
        cnt_r  <= '0;
        tlen_r <= '0;
      end else begin
        st_r   <= st_nxt;
        cnt_r  <= cnt_nxt;
        tlen_r <= tlen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (consume && in_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && in_last_r) begin
      out_total_r  <= res_total;
      out_status_r <= res_status;
    end
  end

  assign out_valid         = out_v_r;
  assign out_total_seconds = out_total_r;
  assign out_status        = out_status_r;

endmodule

// ===== hdl/dur_checker.sv =====
// Port-level checks for the duration string parser, bound to the top level.
`include "assert_macros.svh"

module dur_checker
  import dur_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_total_seconds,
  input logic [2:0]  out_status
);

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `ASSERT_CLK(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_total_seconds) && $stable(out_status))
  `ASSERT_CLK(a_err_zero, clk, rst_n, out_valid && (out_status != ST_OK) |-> out_total_seconds == 64'd0)
  `ASSERT_CLK(a_stall_cause, clk, rst_n, !in_ready |-> out_valid && !out_ready)
  `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid && in_ready)

endmodule

bind duration_string_parser dur_checker u_dur_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_total_seconds (out_total_seconds),
  .out_status        (out_status)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the duration string parser: stimulus, prediction and checks.
`timescale 1ns / 100ps

module tb_top
  import dur_pkg::*;
();

  // Widths and limits of the parser as the predictor sees them.
  localparam int          BUF_LEN     = BUFFER_SIZE_DEF;
  localparam logic [63:0] MAX_VALUE   = 64'd1000000000;
  localparam logic [63:0] SEC_WEEK    = 64'd604800;
  localparam logic [63:0] SEC_DAY     = 64'd86400;
  localparam logic [63:0] SEC_HOUR    = 64'd3600;
  localparam logic [63:0] SEC_MINUTE  = 64'd60;
  localparam logic [63:0] MS_PER_SEC  = 64'd1000;

  // Run shape: item budget, quiet tail, long receiver hold-off, drain and timeout.
  localparam int ITEM_GOAL    = 1650;
  localparam int CALM_ITEMS   = 150;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT_NS   = 2000000;

  // One input word as it waits in the stimulus queue. The hold bit makes the
  // sender wait until every expected result has been received before offering it.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       hold;
  } char_word_t;

  // One predicted result word.
  typedef struct packed {
    logic [63:0] total;
    logic [2:0]  status;
  } duration_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_code = 8'd0;
  logic        in_is_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_total_seconds;
  logic [2:0]  out_status;

  duration_string_parser dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_code      (in_char_code),
    .in_is_last        (in_is_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_total_seconds (out_total_seconds),
    .out_status        (out_status)
  );

  // Stimulus words not yet offered, and results predicted but not yet seen.
  char_word_t       char_queue[$];
  duration_result_t pending_durations[$];
  logic [7:0]       text_q[$];

  int n_items;
  int n_strings;
  int n_bytes_taken;
  int n_results;
  int n_mismatch;
  int status_seen[8];

  // Set by the monitor at a rising edge when a word was taken; read by the
  // driver at the following falling edge.
  logic in_took = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset is held low at the start and released at a falling edge.
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_top NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Duration predictor. It keeps its own copy of the parser state and walks
  // through the same phases: leading whitespace, sign, gap between tokens,
  // digits, whitespace after digits, a pending 'm' that may become "ms", the
  // error sink and the end of a string once a zero byte has been seen.
  // ---------------------------------------------------------------------------
  phase_t      dp_phase;
  logic        dp_negative;
  logic [63:0] dp_sum;
  logic [63:0] dp_value;
  logic        dp_big;
  int          dp_span;
  int          dp_trim;
  logic [2:0]  dp_err;

  function automatic void clear_parser();
    dp_phase    = PH_LEAD;
    dp_negative = 1'b0;
    dp_sum      = 64'd0;
    dp_value    = 64'd0;
    dp_big      = 1'b0;
    dp_span     = 0;
    dp_trim     = 0;
    dp_err      = ST_OK;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Only the first error of a string is kept; the parser then ignores the rest.
  function automatic void raise_error(input logic [2:0] code);
    if (dp_err == ST_OK) dp_err = code;
    dp_phase = PH_ERR;
  endfunction

  function automatic void add_units(input logic [63:0] scale);
    dp_sum   = dp_sum + dp_value * scale;
    dp_phase = PH_GAP;
  endfunction

  // Between tokens only whitespace or the first digit of a number may come.
  function automatic void take_gap(input logic [7:0] c);
    if (is_digit(c)) begin
      dp_value = 64'(c - "0");
      dp_big   = 1'b0;
      dp_phase = PH_NUM;
    end else if (!is_space(c)) begin
      raise_error(ST_EXP_NUM);
    end
  endfunction

  // A byte after a number: a unit letter, or else the number is bare seconds
  // and the byte is handled as if it stood in a gap.
  function automatic void take_unit(input logic [7:0] c);
    case (c)
      "w", "W": add_units(SEC_WEEK);
      "d", "D": add_units(SEC_DAY);
      "h", "H": add_units(SEC_HOUR);
      "M":      add_units(SEC_MINUTE);
      "s", "S": add_units(64'd1);
      "m":      dp_phase = PH_MPEND;
      default: begin
        add_units(64'd1);
        take_gap(c);
      end
    endcase
  endfunction

  function automatic void take_char(input logic [7:0] c);
    case (dp_phase)
      PH_LEAD: begin
        if (c == "-") begin
          dp_negative = 1'b1;
          dp_phase    = PH_SIGN;
        end else if (c == "+") begin
          dp_phase = PH_SIGN;
        end else if (!is_space(c)) begin
          dp_phase = PH_GAP;
          take_gap(c);
        end
      end
      PH_SIGN: begin
        if (!is_space(c)) begin
          dp_phase = PH_GAP;
          take_gap(c);
        end
      end
      PH_GAP: take_gap(c);
      PH_NUM: begin
        if (is_digit(c)) begin
          // The value saturates just above the limit so it stays in 31 bits.
          dp_value = dp_value * 64'd10 + 64'(c - "0");
          if (dp_value > MAX_VALUE) begin
            dp_value = MAX_VALUE + 64'd1;
            dp_big   = 1'b1;
          end
        end else if (dp_big) begin
          raise_error(ST_RANGE);
        end else if (is_space(c)) begin
          dp_phase = PH_NUMSP;
        end else begin
          take_unit(c);
        end
      end
      PH_NUMSP: if (!is_space(c)) take_unit(c);
      PH_MPEND: begin
        // Only a lowercase 's' turns a pending 'm' into milliseconds.
        if (c == "s") begin
          dp_sum   = dp_sum + dp_value / MS_PER_SEC;
          dp_phase = PH_GAP;
        end else begin
          add_units(SEC_MINUTE);
          take_gap(c);
        end
      end
      default: ;
    endcase
  endfunction

  // Closes the string at a zero byte or at the last byte.
  function automatic void close_string();
    case (dp_phase)
      PH_LEAD:  raise_error(ST_EMPTY);
      PH_SIGN:  raise_error(ST_SIGN_ONLY);
      PH_NUM:   if (dp_big) raise_error(ST_RANGE); else add_units(64'd1);
      PH_NUMSP: add_units(64'd1);
      PH_MPEND: add_units(SEC_MINUTE);
      default: ;
    endcase
    dp_phase = PH_END;
  endfunction

  // Advances the predictor by one byte; on the last byte it yields the result.
  function automatic void parse_duration_byte(input logic [7:0] c, input logic last,
                                              output logic emit,
                                              output duration_result_t res);
    logic ws;
    emit       = 1'b0;
    res.total  = 64'd0;
    res.status = ST_OK;
    if (dp_phase != PH_END) begin
      if (c == 8'd0) begin
        close_string();
      end else begin
        ws = is_space(c);
        // Leading whitespace is not counted; trailing whitespace counts toward
        // the span but never moves the trimmed length.
        if (dp_phase != PH_LEAD || !ws) begin
          if (dp_span < BUF_LEN) dp_span++;
          if (!ws) dp_trim = dp_span;
        end
        take_char(c);
      end
    end
    if (last) begin
      if (dp_phase != PH_END) close_string();
      res.status = dp_err;
      // An over-long string beats every error except an empty one.
      if (res.status != ST_EMPTY && dp_trim >= BUF_LEN) res.status = ST_TOO_LONG;
      if (res.status == ST_OK) res.total = dp_negative ? -dp_sum : dp_sum;
      emit = 1'b1;
      clear_parser();
    end
  endfunction

  initial clear_parser();

  // ---------------------------------------------------------------------------
  // Stimulus construction. Strings are assembled in text_q and then moved to
  // the word queue with the last flag on their final byte.
  // ---------------------------------------------------------------------------
  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic flush_text(input logic hold);
    char_word_t w;
    for (int i = 0; i < text_q.size(); i++) begin
      w.code = text_q[i];
      w.last = (i == text_q.size() - 1);
      w.hold = hold && (i == 0);
      char_queue.push_back(w);
    end
    n_items += text_q.size();
    n_strings++;
    text_q.delete();
  endtask

  function automatic logic [7:0] ws_byte();
    case ($urandom_range(0, 5))
      0:       return 8'd9;
      1:       return 8'd10;
      2:       return 8'd11;
      3:       return 8'd12;
      4:       return 8'd13;
      default: return 8'd32;
    endcase
  endfunction

  initial begin
    int          kind;
    int          ntok;
    int          len_goal;
    longint unsigned v;
    logic [7:0]  digits[$];
    string       long_pattern;

    long_pattern = "12h ";

    // Directed strings: an empty one, a bare sign, a bare number, the week, day,
    // hour and minute units, milliseconds, uppercase "Ms", an unknown byte, a
    // zero byte that ends the string early and a sign followed by spaces.
    add_str(" ");    flush_text(1'b0);
    add_str("-");    flush_text(1'b0);
    add_str("9");    flush_text(1'b0);
    add_str("2W");   flush_text(1'b0);
    add_str("3ms");  flush_text(1'b0);
    add_str("2M");   flush_text(1'b0);
    add_str("1Ms");  flush_text(1'b0);
    add_str("x");    flush_text(1'b0);
    add_str("1d");   text_q.push_back(8'd0); add_str("z"); flush_text(1'b0);
    add_str(" + 7h"); flush_text(1'b0);

    while (n_items < ITEM_GOAL) begin
      kind = $urandom_range(0, 99);
      if (n_strings == 30 || n_strings == 60) begin
        // Two long strings around the buffer size: one just fits, one does not
        // and also drives the length counters into saturation.
        len_goal = (n_strings == 30) ? BUF_LEN - 1 : BUF_LEN + 8;
        text_q.push_back(ws_byte());
        for (int k = 0; k < len_goal - 1; k++) text_q.push_back(long_pattern[k % 4]);
        text_q.push_back("7");
        text_q.push_back(ws_byte());
        text_q.push_back(ws_byte());
        flush_text(1'b1);
      end else begin
        if (kind < 4) begin
          repeat ($urandom_range(1, 3)) text_q.push_back(ws_byte());
        end else if (kind < 7) begin
          text_q.push_back($urandom_range(0, 1) ? "-" : "+");
          repeat ($urandom_range(0, 2)) text_q.push_back(ws_byte());
        end else if (kind < 12) begin
          repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          // Well-formed duration with random content.
          repeat ($urandom_range(0, 2)) text_q.push_back(ws_byte());
          case ($urandom_range(0, 7))
            0, 1: text_q.push_back("-");
            2:    text_q.push_back("+");
            default: ;
          endcase
          if ($urandom_range(0, 5) == 0) text_q.push_back(ws_byte());
          ntok = $urandom_range(1, 4);
          for (int t = 0; t < ntok; t++) begin
            case ($urandom_range(0, 15))
              0, 1, 2, 3, 4, 5, 6, 7: v = $urandom_range(0, 99);
              8, 9, 10, 11:           v = $urandom_range(0, 99999);
              12:                     v = 64'd999999990 + $urandom_range(0, 20);
              13:                     v = {$urandom, $urandom};
              14:                     v = 0;
              default:                v = $urandom_range(0, 1000000000);
            endcase
            if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) text_q.push_back("0");
            digits.delete();
            do begin
              digits.push_front(8'("0" + v % 10));
              v = v / 10;
            end while (v != 0);
            foreach (digits[i]) text_q.push_back(digits[i]);
            if ($urandom_range(0, 5) == 0) text_q.push_back(ws_byte());
            case ($urandom_range(0, 13))
              0:       add_str("w");
              1:       add_str("W");
              2:       add_str("d");
              3:       add_str("D");
              4:       add_str("h");
              5:       add_str("H");
              6:       add_str("m");
              7:       add_str("M");
              8:       add_str("s");
              9:       add_str("S");
              10:      add_str("ms");
              11:      add_str("mS");
              12:      add_str("Ms");
              default: text_q.push_back(ws_byte());
            endcase
            if ($urandom_range(0, 2) == 0) text_q.push_back(ws_byte());
          end
          repeat ($urandom_range(0, 2)) text_q.push_back(ws_byte());
          // Now and then a byte is replaced by noise, or a zero byte ends the
          // string early with junk after it.
          if ($urandom_range(0, 7) == 0)
            text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 15) == 0) begin
            text_q.push_back(8'd0);
            repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
          end
        end
        flush_text($urandom_range(0, 39) == 0);
      end
    end

    // Wait for every word to be taken, then for every result, then let the
    // pipeline settle so that a stray extra result would still be caught.
    while (char_queue.size() != 0 || in_valid) @(posedge clk);
    while (pending_durations.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Parsed %0d strings from %0d characters; %0d results compared, %0d mismatches.",
             n_strings, n_bytes_taken, n_results, n_mismatch);
    $display("Status mix: ok %0d, empty %0d, too long %0d, sign only %0d, bad number %0d, range %0d.",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_TOO_LONG],
             status_seen[ST_SIGN_ONLY], status_seen[ST_EXP_NUM], status_seen[ST_RANGE]);
    if (n_mismatch == 0 && pending_durations.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver. Words change at the falling edge. Once a word is offered it stays
  // until taken. Idle gaps come in bursts at a rate that is redrawn every 200
  // words; the tail of the run has no gaps at all.
  // ---------------------------------------------------------------------------
  int gap_left = 0;
  int drv_rate = 0;
  int n_sent   = 0;

  always @(negedge clk) begin
    char_word_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (char_queue.size() == 0 ||
                   (char_queue[0].hold && pending_durations.size() != 0)) begin
        // Nothing to send, or a pause until the parser has delivered everything.
        in_valid <= 1'b0;
      end else begin
        cur = char_queue.pop_front();
        in_char_code <= cur.code;
        in_is_last   <= cur.last;
        in_valid     <= 1'b1;
        if (char_queue.size() >= CALM_ITEMS && drv_rate != 0 &&
            $urandom_range(0, 7) < drv_rate)
          gap_left = $urandom_range(1, 10);
        n_sent++;
        if (n_sent % 200 == 0) drv_rate = $urandom_range(0, 3);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. out_ready changes at the falling edge with its own stall bursts.
  // After twenty results it holds off for a long stretch while the sender keeps
  // going, so the result register fills and the parser must stall its input.
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  int stall_left = 0;
  int rcv_rate = 2;
  int rcv_tick = 0;
  logic long_hold_done = 1'b0;

  always @(negedge clk) begin
    rcv_tick++;
    if (rcv_tick % 256 == 0) rcv_rate = $urandom_range(0, 3);
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!long_hold_done && n_results >= 20) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (char_queue.size() >= CALM_ITEMS && rcv_rate != 0 &&
          $urandom_range(0, 7) < rcv_rate)
        stall_left = $urandom_range(1, 10);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. At each rising edge an accepted input word advances the predictor,
  // and an accepted result word is checked field by field against the oldest
  // prediction. The input side is handled first, though a result can never
  // belong to a word taken at the same edge.
  // ---------------------------------------------------------------------------
  function automatic void note_mismatch(input string msg);
    n_mismatch++;
    if (n_mismatch <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin : monitor
    logic             emit;
    duration_result_t res;
    duration_result_t want;
    in_took = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        n_bytes_taken++;
        parse_duration_byte(in_char_code, in_is_last, emit, res);
        if (emit) pending_durations.push_back(res);
      end
      if (out_valid && out_ready) begin
        if (pending_durations.size() == 0) begin
          note_mismatch($sformatf("unexpected result: total_seconds %0d status %0d",
                                  $signed(out_total_seconds), out_status));
        end else begin
          want = pending_durations.pop_front();
          n_results++;
          status_seen[want.status]++;
          if (out_total_seconds !== want.total)
            note_mismatch($sformatf("total_seconds expected %0d got %0d",
                                    $signed(want.total), $signed(out_total_seconds)));
          if (out_status !== want.status)
            note_mismatch($sformatf("status expected %0d got %0d", want.status, out_status));
        end
      end
    end
  end

endmodule
